// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL of this block.
// All three sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ITPA_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// An implication: when ante holds, cons holds in the same cycle.
`define ITPA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// An implication: when ante holds, cons holds in the next cycle.
`define ITPA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/itpa_pkg.sv -----
package itpa_pkg;

  localparam int unsigned ITPA_MAX_WIDTH     = 63;
  localparam int unsigned ITPA_MAX_PRECISION = 61;

  // Enough digit cells for 64 bits in octal, the longest radix.
  localparam int unsigned NUM_DIGITS  = 22;
  localparam int unsigned DIGIT_IDX_W = 5;
  localparam int unsigned VALUE_W     = 64;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef enum logic [1:0] {
    RADIX_OCT = 2'd0,
    RADIX_DEC = 2'd1,
    RADIX_HEX = 2'd2
  } radix_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PLAN,
    ST_EMIT
  } state_e;

  // Output segments in the order in which they appear in the field.
  typedef enum logic [2:0] {
    SEG_LEAD  = 3'd0,
    SEG_SIGN  = 3'd1,
    SEG_PFX0  = 3'd2,
    SEG_PFXX  = 3'd3,
    SEG_ZPAD  = 3'd4,
    SEG_PREC  = 3'd5,
    SEG_DIGS  = 3'd6,
    SEG_TRAIL = 3'd7
  } seg_e;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  radix;
    logic        signed_conv;
    logic        left_justify;
    logic        force_plus;
    logic        space_sign;
    logic        zero_pad;
    logic        lower_case;
    logic        alt_prefix;
    logic [5:0]  width;
    logic [5:0]  min_digits;
  } itpa_in_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } itpa_out_t;

  typedef struct packed {
    logic   clear;
    logic   shift;
    radix_e radix;
  } chain_ctrl_t;

  function automatic logic [7:0] digit_char(logic [3:0] d, logic lc);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0, d};
    end else begin
      c = (CH_UPPER_A + {4'b0, d} - 8'd10) | (lc ? CASE_BIT : 8'h00);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/itpa_digit_cell.sv -----
module itpa_digit_cell
  import itpa_pkg::*;
(
  input  logic        clk_i,
  input  chain_ctrl_t ctrl_i,
  input  logic        carry_i,
  output logic [3:0]  digit_o,
  output logic        carry_o
);

  logic [3:0] digit_q, digit_d;
  logic [3:0] half;
  logic [4:0] modulus;
  logic [4:0] doubled;

  always_comb begin
    unique case (ctrl_i.radix)
      RADIX_OCT: half = 4'd4;
      RADIX_DEC: half = 4'd5;
      RADIX_HEX: half = 4'd8;
      default:   half = 4'd8;
    endcase
  end

  // The digit doubles and takes the bit from below. With an even radix the
  // carry depends on this digit alone, so no carry ripples along the row.
  assign modulus = {half, 1'b0};
  assign carry_o = (digit_q >= half);
  assign doubled = {digit_q, carry_i};

  always_comb begin
    if (ctrl_i.clear) begin
      digit_d = 4'd0;
    end else if (ctrl_i.shift) begin
      digit_d = carry_o ? 4'(doubled - modulus) : doubled[3:0];
    end else begin
      digit_d = digit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule

// ----- rtl/core/itpa_digit_chain.sv -----
module itpa_digit_chain
  import itpa_pkg::*;
(
  input  logic                   clk_i,
  input  chain_ctrl_t            ctrl_i,
  input  logic                   bit_i,
  input  logic [DIGIT_IDX_W-1:0] rd_idx_i,
  output logic [3:0]             rd_digit_o,
  output logic                   rd_carry_o
);

  logic [NUM_DIGITS-1:0][3:0] digit;
  logic [NUM_DIGITS-1:0]      carry;

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic cin;
    if (i == 0) begin : g_first
      assign cin = bit_i;
    end else begin : g_next
      assign cin = carry[i-1];
    end

    itpa_digit_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .carry_i (cin),
      .digit_o (digit[i]),
      .carry_o (carry[i])
    );
  end

  always_comb begin
    if (rd_idx_i < DIGIT_IDX_W'(NUM_DIGITS)) begin
      rd_digit_o = digit[rd_idx_i];
      rd_carry_o = carry[rd_idx_i];
    end else begin
      rd_digit_o = 4'd0;
      rd_carry_o = 1'b0;
    end
  end

endmodule

// ----- rtl/core/int_to_padded_ascii_core.sv -----
// Integer to text in the manner of a printf conversion. A word is taken
// when start_i is high and busy_o is low; busy_o then stays high while the
// word is converted and its field of 1 to 64 characters is emitted, and
// falls as the final character appears. The magnitude is shifted bit by
// bit, all 64 bits for every radix, into a row of 22 digit cells; a
// planning state then sets the padding, and the characters follow one
// per cycle. Each character is shown on res_o for exactly one cycle while
// res_valid_o is high, and the receiver cannot stall the block, so it must
// take every character as it comes. res_o.last marks the final character.
`include "assert_macros.svh"

module int_to_padded_ascii_core
  import itpa_pkg::*;
#(
  parameter int unsigned MAX_WIDTH     = ITPA_MAX_WIDTH,
  parameter int unsigned MAX_PRECISION = ITPA_MAX_PRECISION
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  itpa_in_t  item_i,
  output logic      busy_o,
  output logic      res_valid_o,
  output itpa_out_t res_o
);

  function automatic seg_e first_seg(logic [7:0] m);
    seg_e s;
    s = SEG_DIGS;
    for (int i = 7; i >= 0; i--) begin
      if (m[i]) begin
        s = seg_e'(3'(i));
      end
    end
    return s;
  endfunction

  function automatic logic [5:0] seg_count(seg_e s, logic [5:0] pad, logic [5:0] precz,
                                           logic [5:0] nd);
    logic [5:0] n;
    case (s)
      SEG_LEAD, SEG_ZPAD, SEG_TRAIL: n = pad;
      SEG_PREC:                      n = precz;
      SEG_DIGS:                      n = nd;
      default:                       n = 6'd1;
    endcase
    return n;
  endfunction

  state_e state_q, state_d;

  logic [VALUE_W-1:0]     mag_q, mag_d;
  logic [5:0]             shift_cnt_q, shift_cnt_d;
  logic [DIGIT_IDX_W-1:0] idx_q, idx_d;
  radix_e                 radix_q, radix_d;
  logic                   left_q, left_d;
  logic                   zpad_q, zpad_d;
  logic                   lc_q, lc_d;
  logic                   alt_q, alt_d;
  logic                   zero_q, zero_d;
  logic [7:0]             sign_q, sign_d;
  logic [5:0]             fw_q, fw_d;
  logic [5:0]             prec_q, prec_d;
  logic [5:0]             pad_q, pad_d;
  logic [5:0]             precz_q, precz_d;
  logic [7:0]             pend_q, pend_d;
  logic [5:0]             cnt_q, cnt_d;
  logic [6:0]             rem_q, rem_d;
  itpa_out_t              res_q, res_d;
  logic                   res_valid_q, res_valid_d;

  logic                   accept;
  logic                   neg;
  chain_ctrl_t            chain_ctrl;
  logic [DIGIT_IDX_W-1:0] rd_idx;
  logic [3:0]             rd_digit;
  logic                   rd_carry;

  // Planning terms, valid in ST_PLAN; nd is also used while emitting.
  logic [5:0] nd;
  logic [5:0] prec_eff;
  logic       sign_en;
  logic       pfx0_en;
  logic       pfxx_en;
  logic [7:0] fw_rem;
  logic [5:0] pad_plan;
  logic [7:0] en_plan;
  logic [6:0] total_plan;

  logic [7:0] pend_nx;
  seg_e       seg;

  assign accept = start_i && (state_q == ST_IDLE);
  assign neg    = item_i.signed_conv && item_i.value[VALUE_W-1];

  assign chain_ctrl.clear = accept;
  assign chain_ctrl.shift = (state_q == ST_CONV);
  assign chain_ctrl.radix = radix_q;

  assign seg    = first_seg(pend_q);
  assign rd_idx = (state_q == ST_CONV) ? idx_q : (cnt_q[DIGIT_IDX_W-1:0] - DIGIT_IDX_W'(1));

  itpa_digit_chain u_chain (
    .clk_i      (clk_i),
    .ctrl_i     (chain_ctrl),
    .bit_i      (mag_q[VALUE_W-1]),
    .rd_idx_i   (rd_idx),
    .rd_digit_o (rd_digit),
    .rd_carry_o (rd_carry)
  );

  assign nd       = {1'b0, idx_q} + 6'd1;
  assign prec_eff = (prec_q > nd) ? prec_q : nd;
  assign sign_en  = (sign_q != 8'd0);
  // The octal prefix is a single zero and is dropped when the value is zero.
  assign pfx0_en  = alt_q && ((radix_q == RADIX_HEX) || !zero_q);
  assign pfxx_en  = alt_q && (radix_q == RADIX_HEX);
  assign fw_rem   = {2'b00, fw_q} - {7'd0, sign_en} - {7'd0, pfx0_en} - {7'd0, pfxx_en}
                    - {2'b00, prec_eff};
  assign pad_plan = fw_rem[7] ? 6'd0 : fw_rem[5:0];

  always_comb begin
    en_plan            = 8'd0;
    en_plan[SEG_LEAD]  = (pad_plan != 6'd0) && !left_q && !zpad_q;
    en_plan[SEG_SIGN]  = sign_en;
    en_plan[SEG_PFX0]  = pfx0_en;
    en_plan[SEG_PFXX]  = pfxx_en;
    en_plan[SEG_ZPAD]  = (pad_plan != 6'd0) && zpad_q;
    en_plan[SEG_PREC]  = (prec_eff != nd);
    en_plan[SEG_DIGS]  = 1'b1;
    en_plan[SEG_TRAIL] = (pad_plan != 6'd0) && left_q;
  end

  assign total_plan = {6'd0, sign_en} + {6'd0, pfx0_en} + {6'd0, pfxx_en}
                      + {1'b0, prec_eff} + {1'b0, pad_plan};

  assign pend_nx = pend_q & ~(8'd1 << seg);

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    shift_cnt_d = shift_cnt_q;
    idx_d       = idx_q;
    radix_d     = radix_q;
    left_d      = left_q;
    zpad_d      = zpad_q;
    lc_d        = lc_q;
    alt_d       = alt_q;
    zero_d      = zero_q;
    sign_d      = sign_q;
    fw_d        = fw_q;
    prec_d      = prec_q;
    pad_d       = pad_q;
    precz_d     = precz_q;
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    res_d       = res_q;
    res_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d     = ST_CONV;
          mag_d       = neg ? (~item_i.value + 64'd1) : item_i.value;
          shift_cnt_d = 6'd0;
          idx_d       = '0;
          // Radix code three is handled as hexadecimal.
          radix_d     = (item_i.radix == 2'd0) ? RADIX_OCT :
                        (item_i.radix == 2'd1) ? RADIX_DEC : RADIX_HEX;
          left_d      = item_i.left_justify;
          zpad_d      = item_i.zero_pad && !item_i.left_justify;
          lc_d        = item_i.lower_case;
          alt_d       = item_i.alt_prefix && (item_i.radix != 2'd1);
          zero_d      = (item_i.value == 64'd0);
          if (neg) begin
            sign_d = CH_MINUS;
          end else if (item_i.signed_conv && item_i.force_plus) begin
            sign_d = CH_PLUS;
          end else if (item_i.signed_conv && item_i.space_sign) begin
            sign_d = CH_SPACE;
          end else begin
            sign_d = 8'd0;
          end
          fw_d   = (item_i.width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : item_i.width;
          prec_d = (item_i.min_digits > 6'(MAX_PRECISION)) ? 6'(MAX_PRECISION)
                                                            : item_i.min_digits;
        end
      end

      ST_CONV: begin
        mag_d       = {mag_q[VALUE_W-2:0], 1'b0};
        shift_cnt_d = shift_cnt_q + 6'd1;
        // The digit count grows exactly when the top nonzero cell carries.
        if (rd_carry && (idx_q < DIGIT_IDX_W'(NUM_DIGITS - 1))) begin
          idx_d = idx_q + DIGIT_IDX_W'(1);
        end
        if (shift_cnt_q == 6'd63) begin
          state_d = ST_PLAN;
        end
      end

      ST_PLAN: begin
        state_d = ST_EMIT;
        pad_d   = pad_plan;
        precz_d = prec_eff - nd;
        pend_d  = en_plan;
        rem_d   = total_plan;
        cnt_d   = seg_count(first_seg(en_plan), pad_plan, prec_eff - nd, nd);
      end

      ST_EMIT: begin
        res_valid_d = 1'b1;
        res_d.last  = (rem_q == 7'd1);
        case (seg)
          SEG_SIGN: res_d.ch = sign_q;
          SEG_PFX0: res_d.ch = CH_ZERO;
          SEG_PFXX: res_d.ch = CH_UPPER_X | (lc_q ? CASE_BIT : 8'h00);
          SEG_ZPAD: res_d.ch = CH_ZERO;
          SEG_PREC: res_d.ch = CH_ZERO;
          SEG_DIGS: res_d.ch = digit_char(rd_digit, lc_q);
          default:  res_d.ch = CH_SPACE;
        endcase
        rem_d = rem_q - 7'd1;
        if (cnt_q == 6'd1) begin
          pend_d = pend_nx;
          cnt_d  = seg_count(first_seg(pend_nx), pad_q, precz_q, nd);
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
        if (rem_q == 7'd1) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 8'd0;
      cnt_q       <= 6'd0;
      rem_q       <= 7'd0;
      shift_cnt_q <= 6'd0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      shift_cnt_q <= shift_cnt_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    radix_q <= radix_d;
    left_q  <= left_d;
    zpad_q  <= zpad_d;
    lc_q    <= lc_d;
    alt_q   <= alt_d;
    zero_q  <= zero_d;
    sign_q  <= sign_d;
    fw_q    <= fw_d;
    prec_q  <= prec_d;
    pad_q   <= pad_d;
    precz_q <= precz_d;
    res_q   <= res_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `ITPA_ASSERT_IMP(a_last_frees, res_valid_o && res_o.last, !busy_o, "busy after last word")
  `ITPA_ASSERT_IMP(a_more_pending, res_valid_o && !res_o.last, busy_o, "field ended early")
  `ITPA_ASSERT_IMP(a_emit_has_seg, state_q == ST_EMIT, pend_q != 8'd0, "no segment left")
  `ITPA_ASSERT_NXT(a_accept_quiet, start_i && !busy_o, !res_valid_o, "word right after start")

endmodule

// ----- verif/int_to_padded_ascii_core_tb.sv -----
`timescale 1ns / 1ps

module int_to_padded_ascii_core_tb
  import itpa_pkg::*;
();

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 4;
  localparam int FIELD_LIMIT  = 64;
  // A word holds the block until its field, at most 64 characters, is out.
  localparam int DRAIN_CYCLES = 140;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_WORDS = 160;
  localparam int MAX_REPORTS  = 10;

  // Radix code 3 is not named in the package; the block treats it as hex.
  localparam logic [1:0] RADIX_ALIAS_HEX = 2'd3;
  localparam logic [7:0] NO_SIGN         = 8'h00;

  localparam logic [6:0] FLAG_NONE   = 7'b000_0000;
  localparam logic [6:0] FLAG_SIGNED = 7'b100_0000;
  localparam logic [6:0] FLAG_LEFT   = 7'b010_0000;
  localparam logic [6:0] FLAG_PLUS   = 7'b001_0000;
  localparam logic [6:0] FLAG_SPACE  = 7'b000_1000;
  localparam logic [6:0] FLAG_ZPAD   = 7'b000_0100;
  localparam logic [6:0] FLAG_LOWER  = 7'b000_0010;
  localparam logic [6:0] FLAG_ALT    = 7'b000_0001;

  localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MOST_NEG  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POS  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    itpa_in_t word;
    string    text;
  } directed_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  itpa_in_t  item_i;
  logic      busy_o;
  logic      res_valid_o;
  itpa_out_t res_o;

  logic [7:0]    field_buf[$];
  itpa_out_t     pending_chars[$];
  itpa_out_t     next_char;
  directed_row_t directed_rows[$];

  int cycle_count;
  int mismatch_count;
  int words_sent;
  int directed_words;
  int chars_seen;
  int longest_field;

  int_to_padded_ascii_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (item_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  function automatic itpa_in_t make_word(logic [63:0] value, logic [1:0] radix,
                                         logic [6:0] flags, logic [5:0] width,
                                         logic [5:0] min_digits);
    return itpa_in_t'({value, radix, flags, width, min_digits});
  endfunction

  function automatic void put_run(logic [7:0] c, int n);
    for (int i = 0; i < n; i++) begin
      if (field_buf.size() < FIELD_LIMIT) begin
        field_buf.push_back(c);
      end
    end
  endfunction

  // Builds the characters of one converted field in field_buf.
  function automatic void format_field(itpa_in_t w);
    logic [63:0] mag;
    logic [7:0]  sign_ch;
    logic [7:0]  case_mask;
    logic [7:0]  digs[24];
    logic [3:0]  d;
    int          fw;
    int          prec;
    int          nd;
    bit          is_hex;
    bit          is_dec;
    bit          is_zero;
    bit          use_alt;
    bit          zpad;
    bit          left;

    mag       = w.value;
    is_hex    = (w.radix == RADIX_HEX) || (w.radix == RADIX_ALIAS_HEX);
    is_dec    = (w.radix == RADIX_DEC);
    is_zero   = (mag == '0);
    case_mask = w.lower_case ? CASE_BIT : 8'h00;
    left      = w.left_justify;
    zpad      = w.zero_pad && !left;
    fw        = int'(w.width);
    prec      = int'(w.min_digits);
    sign_ch   = NO_SIGN;
    nd        = 0;
    if (fw > ITPA_MAX_WIDTH) fw = ITPA_MAX_WIDTH;
    if (prec > ITPA_MAX_PRECISION) prec = ITPA_MAX_PRECISION;

    if (w.signed_conv) begin
      if (mag[63]) begin
        sign_ch = CH_MINUS;
        mag     = -mag;
      end else if (w.force_plus) begin
        sign_ch = CH_PLUS;
      end else if (w.space_sign) begin
        sign_ch = CH_SPACE;
      end
    end
    if (sign_ch != NO_SIGN) fw--;

    use_alt = w.alt_prefix && !is_dec;
    if (use_alt) begin
      if (is_hex) fw -= 2;
      else if (!is_zero) fw--;
    end

    // Digits come out least significant first.
    do begin
      if (is_dec) begin
        d   = 4'(mag % 64'd10);
        mag = mag / 64'd10;
      end else if (is_hex) begin
        d   = mag[3:0];
        mag = mag >> 4;
      end else begin
        d   = {1'b0, mag[2:0]};
        mag = mag >> 3;
      end
      digs[nd] = ((d < 4'd10) ? (CH_ZERO + 8'(d)) : (CH_UPPER_A + 8'(d) - 8'd10)) | case_mask;
      nd++;
    end while (mag != '0 && nd < 24);

    if (nd > prec) prec = nd;
    fw -= prec;

    field_buf.delete();
    if (!zpad && !left) begin
      put_run(CH_SPACE, fw);
      fw = 0;
    end
    if (sign_ch != NO_SIGN) put_run(sign_ch, 1);
    if (use_alt) begin
      if (is_hex || !is_zero) put_run(CH_ZERO, 1);
      if (is_hex) put_run(CH_UPPER_X | case_mask, 1);
    end
    if (!left) begin
      put_run(zpad ? CH_ZERO : CH_SPACE, fw);
      fw = 0;
    end
    put_run(CH_ZERO, prec - nd);
    for (int k = nd - 1; k >= 0; k--) put_run(digs[k], 1);
    put_run(CH_SPACE, fw);
  endfunction

  function automatic void queue_field();
    itpa_out_t c;
    foreach (field_buf[i]) begin
      c.ch   = field_buf[i];
      c.last = (i == field_buf.size() - 1);
      pending_chars.push_back(c);
    end
    if (field_buf.size() > longest_field) longest_field = field_buf.size();
  endfunction

  function automatic logic [5:0] random_size();
    case ($urandom_range(3))
      0: return '0;
      1: return 6'($urandom_range(63));
      default: return 6'($urandom_range(16));
    endcase
  endfunction

  function automatic itpa_in_t random_word();
    logic [63:0] v;
    case ($urandom_range(5))
      0: v = 64'($urandom_range(1000));
      1: v = -64'($urandom_range(1, 1000));
      2: v = 64'd1 << $urandom_range(63);
      3: begin
        case ($urandom_range(3))
          0: v = '0;
          1: v = ALL_ONES;
          2: v = MOST_NEG;
          default: v = MOST_POS;
        endcase
      end
      default: v = {$urandom, $urandom};
    endcase
    return make_word(v, 2'($urandom_range(3)), 7'($urandom_range(127)),
                     random_size(), random_size());
  endfunction

  // Offers one word and records its expected characters once it is taken.
  // An empty text means the characters come from format_field.
  task automatic send_word(input itpa_in_t w, input string text, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= w;
    do @(posedge clk_i); while (busy_o);
    if (text.len() == 0) begin
      format_field(w);
    end else begin
      field_buf.delete();
      for (int i = 0; i < text.len(); i++) field_buf.push_back(text[i]);
    end
    queue_field();
    words_sent++;
  endtask

  task automatic wait_until_drained();
    start_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still expected",
               cycle_count, pending_chars.size());
      $display("** int_to_padded_ascii_core: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected character %h last %b", res_o.ch, res_o.last);
        end
      end else begin
        next_char = pending_chars.pop_front();
        if (res_o.ch !== next_char.ch || res_o.last !== next_char.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("character mismatch: expected %h last %b, got %h last %b",
                     next_char.ch, next_char.last, res_o.ch, res_o.last);
          end
        end
      end
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    item_i         = '0;
    cycle_count    = 0;
    mismatch_count = 0;
    words_sent     = 0;
    chars_seen     = 0;
    longest_field  = 0;

    // Fields with a fixed, easily read text.
    directed_rows.push_back('{make_word('0, RADIX_DEC, FLAG_NONE, 6'd0, 6'd0), "0"});
    directed_rows.push_back('{make_word(ALL_ONES, RADIX_HEX, FLAG_NONE, 6'd0, 6'd0),
                              "FFFFFFFFFFFFFFFF"});
    directed_rows.push_back('{make_word(MOST_NEG, RADIX_DEC, FLAG_SIGNED, 6'd0, 6'd0),
                              "-9223372036854775808"});
    directed_rows.push_back('{make_word(ALL_ONES, RADIX_DEC, FLAG_NONE, 6'd0, 6'd0),
                              "18446744073709551615"});
    directed_rows.push_back('{make_word(ALL_ONES, RADIX_OCT, FLAG_NONE, 6'd0, 6'd0),
                              "1777777777777777777777"});
    directed_rows.push_back('{make_word('0, RADIX_HEX, FLAG_ALT | FLAG_LOWER, 6'd0, 6'd0),
                              "0x0"});
    directed_rows.push_back('{make_word('0, RADIX_OCT, FLAG_ALT, 6'd0, 6'd0), "0"});
    directed_rows.push_back('{make_word(64'd5, RADIX_DEC,
                                        FLAG_SIGNED | FLAG_PLUS | FLAG_ZPAD, 6'd4, 6'd0),
                              "+005"});
    directed_rows.push_back('{make_word(ALL_ONES, RADIX_DEC, FLAG_SIGNED | FLAG_LEFT,
                                        6'd5, 6'd0), "-1   "});
    directed_rows.push_back('{make_word(64'd8, RADIX_OCT, FLAG_ALT, 6'd0, 6'd0), "010"});
    directed_rows.push_back('{make_word(64'd255, RADIX_HEX, FLAG_ALT, 6'd0, 6'd0), "0XFF"});
    directed_rows.push_back('{make_word(64'd255, RADIX_HEX, FLAG_LOWER, 6'd0, 6'd0), "ff"});
    directed_rows.push_back('{make_word(64'd42, RADIX_DEC, FLAG_SIGNED | FLAG_SPACE,
                                        6'd0, 6'd0), " 42"});
    directed_rows.push_back('{make_word(64'd42, RADIX_DEC, FLAG_PLUS | FLAG_SPACE,
                                        6'd0, 6'd0), "42"});
    directed_rows.push_back('{make_word(ALL_ONES, RADIX_HEX, FLAG_SIGNED, 6'd0, 6'd0), "-1"});
    // The rest are worked out by format_field.
    directed_rows.push_back('{make_word(ALL_ONES, RADIX_ALIAS_HEX,
                                        FLAG_ALT | FLAG_LOWER | FLAG_ZPAD, 6'd63, 6'd0), ""});
    directed_rows.push_back('{make_word('0, RADIX_DEC, FLAG_NONE, 6'd63, 6'd0), ""});
    directed_rows.push_back('{make_word('0, RADIX_DEC, FLAG_NONE, 6'd0, 6'd61), ""});
    directed_rows.push_back('{make_word(64'd123, RADIX_DEC, FLAG_NONE, 6'd63, 6'd63), ""});
    directed_rows.push_back('{make_word(MOST_NEG, RADIX_HEX, FLAG_SIGNED | FLAG_ALT,
                                        6'd63, 6'd61), ""});
    directed_rows.push_back('{make_word(64'd123, RADIX_DEC,
                                        FLAG_SIGNED | FLAG_LEFT | FLAG_ZPAD, 6'd10, 6'd0), ""});
    directed_rows.push_back('{make_word(64'd7, RADIX_OCT, FLAG_ALT | FLAG_ZPAD,
                                        6'd8, 6'd3), ""});
    directed_rows.push_back('{make_word('0, RADIX_OCT, FLAG_ALT | FLAG_ZPAD, 6'd6, 6'd0), ""});
    directed_rows.push_back('{make_word(-64'd77, RADIX_OCT, FLAG_SIGNED | FLAG_PLUS,
                                        6'd12, 6'd5), ""});
    directed_rows.push_back('{make_word(64'd1, RADIX_DEC,
                                        FLAG_SIGNED | FLAG_SPACE | FLAG_LEFT, 6'd63, 6'd0), ""});
    directed_words = directed_rows.size();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].text, 0);
    end
    wait_until_drained();

    // Back to back, then a mostly idle sender, then a lightly idle one.
    for (int p = 0; p < 3; p++) begin
      for (int n = 0; n < RANDOM_WORDS; n++) begin
        send_word(random_word(), "", (p == 0) ? 0 : ((p == 1) ? 83 : 18));
      end
      wait_until_drained();
    end

    $display("ran %0d words (%0d directed, %0d random) over all radixes and flag mixes",
             words_sent, directed_words, words_sent - directed_words);
    $display("checked %0d characters, longest field %0d, %0d mismatches",
             chars_seen, longest_field, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** int_to_padded_ascii_core: PASSED **");
    end else begin
      $display("** int_to_padded_ascii_core: FAILED **");
    end
    $finish;
  end

endmodule
